@@ src/wfrt_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// wfrt_pkg
// Shared types and constants for the wildcard filter rule table.
// ============================================================================
package wfrt_pkg;

  localparam int ADDR_W  = 32;
  localparam int PORT_W  = 16;
  localparam int WAY_W   = 8;
  localparam int COUNT_W = 5;

  localparam logic [ADDR_W-1:0]  ADDR_WILD = '0;
  localparam logic [PORT_W-1:0]  PORT_WILD = '0;
  localparam logic [WAY_W-1:0]   WAY_WILD  = 8'd42;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

  typedef enum logic [1:0] {
    KIND_ADD        = 2'd0,
    KIND_FIND       = 2'd1,
    KIND_REMOVE     = 2'd2,
    KIND_REMOVE_ALL = 2'd3
  } kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the request and clear the result
    logic match;    // register the match vector against the current table
    logic add;      // insert at the head, or flag the table as full
    logic remove;   // delete the newest matching rule
    logic capture;  // record the newest match as the found rule
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    kind_t kind;
    logic  any_match;
  } ctrl_status_t;

endpackage

@@ src/wfrt_ctrl.sv @@
`timescale 1ns / 1ps
// ============================================================================
// wfrt_ctrl
// Sequencer for one request: match, act, then hold the result until taken.
// ============================================================================
module wfrt_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  logic                    out_stall,
  input  wfrt_pkg::ctrl_status_t  status,
  output wfrt_pkg::ctrl_cmd_t     cmd
);
  import wfrt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_ACT,
    S_RESULT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd.match  = 1'b1;
        state_next = S_ACT;
      end
      S_ACT: begin
        state_next = S_RESULT;
        case (status.kind)
          KIND_ADD: begin
            cmd.add = 1'b1;
          end
          KIND_FIND: begin
            cmd.capture = status.any_match;
          end
          KIND_REMOVE: begin
            cmd.capture = status.any_match;
            cmd.remove  = status.any_match;
          end
          KIND_REMOVE_ALL: begin
            cmd.capture = status.any_match;
            cmd.remove  = status.any_match;
            // Keep going until a fresh match pass finds nothing left.
            if (status.any_match) begin
              state_next = S_MATCH;
            end
          end
          default: begin
            state_next = S_RESULT;
          end
        endcase
      end
      S_RESULT: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_stall  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      in_stall  <= (state_next != S_IDLE);
      out_valid <= (state_next == S_RESULT);
    end
  end

endmodule

@@ src/wfrt_datapath.sv @@
`timescale 1ns / 1ps
// ============================================================================
// wfrt_datapath
// Rule cells with per-slot wildcard compare, shift insert and shift removal.
// ============================================================================
module wfrt_datapath #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  wfrt_pkg::ctrl_cmd_t               cmd,
  output wfrt_pkg::ctrl_status_t            status,
  input  logic [1:0]                        kind,
  input  logic [wfrt_pkg::ADDR_W-1:0]       rule_addr,
  input  logic [wfrt_pkg::PORT_W-1:0]       rule_port,
  input  logic [wfrt_pkg::WAY_W-1:0]        rule_way,
  output logic                              hit,
  output logic [wfrt_pkg::ADDR_W-1:0]       found_addr,
  output logic [wfrt_pkg::PORT_W-1:0]       found_port,
  output logic [wfrt_pkg::WAY_W-1:0]        found_way,
  output logic [wfrt_pkg::COUNT_W-1:0]      removed_count,
  output logic                              table_full,
  output logic [wfrt_pkg::COUNT_W-1:0]      rule_count
);
  import wfrt_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  logic [ADDR_W-1:0] slot_addr [TABLE_DEPTH];
  logic [PORT_W-1:0] slot_port [TABLE_DEPTH];
  logic [WAY_W-1:0]  slot_way  [TABLE_DEPTH];

  kind_t             q_kind;
  logic [ADDR_W-1:0] q_addr;
  logic [PORT_W-1:0] q_port;
  logic [WAY_W-1:0]  q_way;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  removed;
  logic              hit_q;
  logic              full_q;

  logic [TABLE_DEPTH-1:0] match_next;
  logic [TABLE_DEPTH-1:0] match_q;
  logic [TABLE_DEPTH-1:0] match_neg;
  logic [TABLE_DEPTH-1:0] first_hot;
  logic [TABLE_DEPTH-1:0] from_first;

  logic [ADDR_W-1:0] sel_addr;
  logic [PORT_W-1:0] sel_port;
  logic [WAY_W-1:0]  sel_way;

  logic              is_full;
  logic [EXT_W-1:0]  count_ext;
  logic [EXT_W-1:0]  removed_ext;

  // Each cell compares its own rule against the held request.
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      match_next[i] = (CNT_W'(i) < count) &&
                      (slot_addr[i] == q_addr || slot_addr[i] == ADDR_WILD ||
                       q_addr == ADDR_WILD) &&
                      (slot_port[i] == q_port || slot_port[i] == PORT_WILD ||
                       q_port == PORT_WILD) &&
                      (slot_way[i] == q_way || slot_way[i] == WAY_WILD ||
                       q_way == WAY_WILD);
    end
  end

  // Two's complement isolates the lowest set bit (newest match) and marks
  // every slot at or behind it, which is the part that shifts on removal.
  assign match_neg  = ~match_q + TABLE_DEPTH'(1);
  assign first_hot  = match_q & match_neg;
  assign from_first = match_q | match_neg;

  always_comb begin
    sel_addr = '0;
    sel_port = '0;
    sel_way  = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      sel_addr = sel_addr | (slot_addr[i] & {ADDR_W{first_hot[i]}});
      sel_port = sel_port | (slot_port[i] & {PORT_W{first_hot[i]}});
      sel_way  = sel_way  | (slot_way[i]  & {WAY_W{first_hot[i]}});
    end
  end

  assign is_full = (count == CNT_W'(TABLE_DEPTH));

  // Rule cells and request fields carry no reset.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_kind <= kind_t'(kind);
      q_addr <= rule_addr;
      q_port <= rule_port;
      q_way  <= rule_way;
    end
    if (cmd.add && !is_full) begin
      for (int i = TABLE_DEPTH - 1; i > 0; i--) begin
        slot_addr[i] <= slot_addr[i-1];
        slot_port[i] <= slot_port[i-1];
        slot_way[i]  <= slot_way[i-1];
      end
      slot_addr[0] <= q_addr;
      slot_port[0] <= q_port;
      slot_way[0]  <= q_way;
    end else if (cmd.remove) begin
      for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
        if (from_first[i]) begin
          slot_addr[i] <= slot_addr[i+1];
          slot_port[i] <= slot_port[i+1];
          slot_way[i]  <= slot_way[i+1];
        end
      end
    end
    if (cmd.load) begin
      found_addr <= '0;
      found_port <= '0;
      found_way  <= '0;
    end else if (cmd.capture && !hit_q) begin
      found_addr <= sel_addr;
      found_port <= sel_port;
      found_way  <= sel_way;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      removed <= '0;
      hit_q   <= 1'b0;
      full_q  <= 1'b0;
      match_q <= '0;
    end else begin
      if (cmd.match) begin
        match_q <= match_next;
      end
      if (cmd.load) begin
        removed <= '0;
        hit_q   <= 1'b0;
        full_q  <= 1'b0;
      end else begin
        if (cmd.capture) begin
          hit_q <= 1'b1;
        end
        if (cmd.add) begin
          if (is_full) begin
            full_q <= 1'b1;
          end else begin
            count <= count + CNT_W'(1);
          end
        end else if (cmd.remove) begin
          count   <= count - CNT_W'(1);
          removed <= removed + CNT_W'(1);
        end
      end
    end
  end

  assign status.kind      = q_kind;
  assign status.any_match = |match_q;

  assign count_ext   = EXT_W'(count);
  assign removed_ext = EXT_W'(removed);

  assign hit           = hit_q;
  assign table_full    = full_q;
  assign rule_count    = (count_ext > EXT_W'(COUNT_MAX)) ? COUNT_MAX
                                                         : count_ext[COUNT_W-1:0];
  assign removed_count = (removed_ext > EXT_W'(COUNT_MAX)) ? COUNT_MAX
                                                           : removed_ext[COUNT_W-1:0];

endmodule

@@ src/wildcard_filter_rule_table.sv @@
`timescale 1ns / 1ps
// ============================================================================
// wildcard_filter_rule_table
// Newest-first packet-filter rule table with wildcard matching.
// ============================================================================
// A request enters on in_valid/in_stall carrying kind, rule_addr, rule_port
// and rule_way; it is taken at an edge where in_valid is high and in_stall low.
// One result per request leaves on out_valid/out_stall and is held, unchanged,
// for as long as out_stall is high. Only one request is in the block at a time.
// Every request runs a match pass and an action step; out_valid rises after
// the match and action states, and in_stall drops at the edge where the result
// is taken. A remove-all repeats the match and action pair once per deleted
// rule. The match compare runs in parallel across all cells, and removal shifts
// the cells behind the newest match down by one slot, so each deleted rule
// needs its own match and action pair.
// A synchronous reset empties the table and returns the block to idle; no
// clearing pass is needed. rule_count and removed_count saturate at 31.
// ============================================================================
module wildcard_filter_rule_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    kind,
  input  logic [wfrt_pkg::ADDR_W-1:0]   rule_addr,
  input  logic [wfrt_pkg::PORT_W-1:0]   rule_port,
  input  logic [wfrt_pkg::WAY_W-1:0]    rule_way,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          hit,
  output logic [wfrt_pkg::ADDR_W-1:0]   found_addr,
  output logic [wfrt_pkg::PORT_W-1:0]   found_port,
  output logic [wfrt_pkg::WAY_W-1:0]    found_way,
  output logic [wfrt_pkg::COUNT_W-1:0]  removed_count,
  output logic                          table_full,
  output logic [wfrt_pkg::COUNT_W-1:0]  rule_count
);
  import wfrt_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  wfrt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  wfrt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .kind          (kind),
    .rule_addr     (rule_addr),
    .rule_port     (rule_port),
    .rule_way      (rule_way),
    .hit           (hit),
    .found_addr    (found_addr),
    .found_port    (found_port),
    .found_way     (found_way),
    .removed_count (removed_count),
    .table_full    (table_full),
    .rule_count    (rule_count)
  );

  // While a result is waiting, no new request may enter.
  a_result_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("request accepted while a result is pending");

  // A newly taken request cannot produce its result in the next cycle.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !out_valid)
    else $error("result appeared without a match pass");

  // A rejected add neither hits nor deletes anything.
  a_full_is_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && table_full) |-> (!hit && removed_count == '0))
    else $error("full flag raised together with a hit or a removal");

  // A miss reports an all-zero rule.
  a_miss_zero_rule: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |->
      (found_addr == '0 && found_port == '0 && found_way == '0))
    else $error("miss reported a nonzero rule");

endmodule
